[src/sample_trend_monitor_assert.svh]
// Assertion macros for the top-level design file. Each one samples on the rising
// edge of clk and is disabled while arst_n is low.
`ifndef SAMPLE_TREND_MONITOR_ASSERT_SVH
`define SAMPLE_TREND_MONITOR_ASSERT_SVH

// A condition that must hold on every clock edge.
`define STM_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that must hold on the edge after the trigger.
`define STM_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);

`endif

[src/stm_pkg.sv]
package stm_pkg;

	localparam int SAMPLE_W = 32;
	localparam int DIFF_W   = 33;
	localparam int MAG_W    = 33;
	localparam int CFG_W    = 31;
	localparam int OSC_W    = 4;
	localparam int IDX_W    = 2;

	// Eight cells hold the steps between the nine newest samples.
	localparam int NUM_CELLS = 8;

	localparam int CONV_STEPS       = 5;
	localparam int CONV_MIN_FILL    = 6;
	localparam int DIV_MIN_FILL     = 3;
	localparam int DIV_PAIRS        = 3;
	localparam int DIV_HITS         = 3;
	localparam int OSC_PAIR_FILL    = 3;
	localparam int IMPROVE_MIN_FILL = 3;

	// Growth test: older * GROW_NUM > newer * GROW_DEN, a ratio of 1.2.
	localparam int GROW_NUM = 5;
	localparam int GROW_DEN = 6;

	localparam logic [IDX_W-1:0] REG_CONVERGE_LIMIT = 2'd0;
	localparam logic [IDX_W-1:0] REG_DIVERGE_LIMIT  = 2'd1;
	localparam logic [IDX_W-1:0] REG_OSC_CYCLES     = 2'd2;
	localparam logic [IDX_W-1:0] REG_STABLE_LIMIT   = 2'd3;

	localparam logic [CFG_W-1:0] CONVERGE_LIMIT_RST = 31'd66;
	localparam logic [CFG_W-1:0] DIVERGE_LIMIT_RST  = 31'h7FFF_FFFF;
	localparam logic [OSC_W-1:0] OSC_CYCLES_RST     = 4'd3;
	localparam logic [CFG_W-1:0] STABLE_LIMIT_RST   = 31'd14624;

	localparam logic [SAMPLE_W-1:0] STEP_MAX = 32'h7FFF_FFFF;
	localparam logic [SAMPLE_W-1:0] STEP_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             pos;
		logic             neg;
	} cell_t;

	typedef struct packed {
		cell_t d;
		logic  grow;
		logic  flip;
	} cell_state_t;

	typedef struct packed {
		logic converged;
		logic diverging;
		logic oscillating;
	} flags_t;

	function automatic logic [SAMPLE_W-1:0] mag32(input logic [SAMPLE_W-1:0] v);
		mag32 = v[SAMPLE_W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [MAG_W-1:0] mag33(input logic [DIFF_W-1:0] v);
		mag33 = v[DIFF_W-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

[src/stm_cell.sv]
module stm_cell (
	input  logic                 clk,
	input  logic                 shift,
	input  stm_pkg::cell_t       din,
	output stm_pkg::cell_state_t q
);

	localparam int PROD_W = stm_pkg::MAG_W + 3;

	stm_pkg::cell_state_t state_q;
	logic [PROD_W-1:0]    older_x;
	logic [PROD_W-1:0]    newer_x;
	logic                 grow;
	logic                 flip;

	// The held step moves on to the older neighbor, so the pair bits relate
	// the incoming step to the one this cell holds now.
	assign older_x = PROD_W'(state_q.d.mag) * PROD_W'(stm_pkg::GROW_NUM);
	assign newer_x = PROD_W'(din.mag) * PROD_W'(stm_pkg::GROW_DEN);
	assign grow    = older_x > newer_x;
	assign flip    = (din.pos && state_q.d.neg) || (din.neg && state_q.d.pos);

	always_ff @(posedge clk) begin
		if (shift) begin
			state_q.d    <= din;
			state_q.grow <= grow;
			state_q.flip <= flip;
		end
	end

	assign q = state_q;

endmodule

[src/stm_flags.sv]
module stm_flags #(
	parameter int FILL_W = 5
) (
	input  stm_pkg::cell_state_t              cells [stm_pkg::NUM_CELLS],
	input  logic [FILL_W-1:0]                 fill,
	input  logic [stm_pkg::SAMPLE_W-1:0]      newest,
	input  logic [stm_pkg::CFG_W-1:0]         converge_limit,
	input  logic [stm_pkg::CFG_W-1:0]         diverge_limit,
	input  logic [stm_pkg::OSC_W-1:0]         osc_cycles,
	output stm_pkg::flags_t                   flags
);

	localparam int CMP_W = (FILL_W > stm_pkg::OSC_W + 1) ? FILL_W : stm_pkg::OSC_W + 1;

	logic [CMP_W-1:0]             fill_x;
	logic [CMP_W-1:0]             osc_x2;
	logic [stm_pkg::SAMPLE_W-1:0] newest_mag;
	logic                         too_big;
	logic                         hits;
	logic [2:0]                   hit_sum;
	logic [stm_pkg::OSC_W-1:0]    changes;
	logic                         conv;

	assign fill_x     = CMP_W'(fill);
	assign osc_x2     = CMP_W'({osc_cycles, 1'b0});
	assign newest_mag = stm_pkg::mag32(newest);
	assign too_big    = newest_mag > {1'b0, diverge_limit};

	always_comb begin
		conv = fill_x >= CMP_W'(stm_pkg::CONV_MIN_FILL);
		for (int j = 0; j < stm_pkg::CONV_STEPS; j++) begin
			if (cells[j].d.mag >= stm_pkg::MAG_W'(converge_limit)) begin
				conv = 1'b0;
			end
		end
	end

	// The newest step is compared against zero, then each older step against
	// the one just newer than it.
	always_comb begin
		hit_sum = {2'b00, cells[0].d.pos | cells[0].d.neg};
		for (int j = 0; j < stm_pkg::DIV_PAIRS; j++) begin
			if (cells[j].grow && fill_x >= CMP_W'(j + stm_pkg::DIV_MIN_FILL)) begin
				hit_sum = hit_sum + 3'd1;
			end
		end
		hits = hit_sum >= 3'(stm_pkg::DIV_HITS);
	end

	always_comb begin
		changes = '0;
		for (int j = 0; j < stm_pkg::NUM_CELLS; j++) begin
			if (cells[j].flip && fill_x >= CMP_W'(j + stm_pkg::OSC_PAIR_FILL)) begin
				changes = changes + 1'b1;
			end
		end
	end

	assign flags.converged   = conv;
	assign flags.diverging   = (fill_x >= CMP_W'(stm_pkg::DIV_MIN_FILL)) && (too_big || hits);
	assign flags.oscillating = (fill_x >= osc_x2) && (changes >= osc_cycles);

endmodule

[src/sample_trend_monitor.sv]
// Channel   Direction  Handshake                     Word
// sample    in         sample_valid / sample_stall   sample, restart
// result    out        result_valid / result_stall   step, update_count, five flags
// config    in         cfg_we                        cfg_index, cfg_data
//
// The step is formed as a word is accepted and registered in the first stage; the
// word then shifts into the cell chain in the second stage, where the flags read
// the cells and are captured in the result register. A new word is taken only
// after the last one has left the first stage. The result register frees the
// input side, so one more word is taken while a result waits on result_stall.
// Reset clears the fill count, last step and counter, and loads configuration
// defaults; cells hold no reset and are read only as far as the fill count reaches.
`include "sample_trend_monitor_assert.svh"

module sample_trend_monitor #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [stm_pkg::SAMPLE_W-1:0] sample,
	input  logic                                restart,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [stm_pkg::SAMPLE_W-1:0] step,
	output logic        [stm_pkg::SAMPLE_W-1:0] update_count,
	output logic                                is_stable,
	output logic                                is_converged,
	output logic                                is_diverging,
	output logic                                is_oscillating,
	output logic                                is_improving,
	input  logic                                cfg_we,
	input  logic        [stm_pkg::IDX_W-1:0]    cfg_index,
	input  logic        [stm_pkg::CFG_W-1:0]    cfg_data
);

	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SW     = stm_pkg::SAMPLE_W;

	logic [stm_pkg::CFG_W-1:0] converge_limit_q;
	logic [stm_pkg::CFG_W-1:0] diverge_limit_q;
	logic [stm_pkg::OSC_W-1:0] osc_cycles_q;
	logic [stm_pkg::CFG_W-1:0] stable_limit_q;

	logic [FILL_W-1:0] fill_q;
	logic [SW-1:0]     sample_q;
	logic [SW-1:0]     last_step_q;
	logic [SW-1:0]     count_q;

	logic                      v_s1_q;
	logic [stm_pkg::DIFF_W-1:0] diff_s1;
	logic [SW-1:0]             step_s1;
	logic [SW-1:0]             prev_s1;
	logic [SW-1:0]             cnt_s1;
	logic                      first_s1;

	logic          v_s2_q;
	logic [SW-1:0] step_s2;
	logic [SW-1:0] cnt_s2;
	logic          stable_s2;
	logic          improving_s2;

	logic            res_valid_q;
	logic [SW-1:0]   res_step_q;
	logic [SW-1:0]   res_count_q;
	logic            res_stable_q;
	logic            res_improving_q;
	stm_pkg::flags_t res_flags_q;

	logic                       accept;
	logic                       adv;
	logic                       first;
	logic [stm_pkg::DIFF_W-1:0] diff;
	logic [SW-1:0]              step_sat;
	logic [SW-1:0]              count_next;
	logic [FILL_W-1:0]          fill_next;
	logic [stm_pkg::DIFF_W-1:0] accel;
	logic                       stable;
	logic                       improving;
	stm_pkg::cell_t             feed;
	stm_pkg::cell_t             cell_in [stm_pkg::NUM_CELLS];
	stm_pkg::cell_state_t       cell_q  [stm_pkg::NUM_CELLS];
	stm_pkg::flags_t            flags;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			converge_limit_q <= stm_pkg::CONVERGE_LIMIT_RST;
			diverge_limit_q  <= stm_pkg::DIVERGE_LIMIT_RST;
			osc_cycles_q     <= stm_pkg::OSC_CYCLES_RST;
			stable_limit_q   <= stm_pkg::STABLE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				stm_pkg::REG_CONVERGE_LIMIT: converge_limit_q <= cfg_data;
				stm_pkg::REG_DIVERGE_LIMIT:  diverge_limit_q  <= cfg_data;
				stm_pkg::REG_OSC_CYCLES:     osc_cycles_q     <= cfg_data[stm_pkg::OSC_W-1:0];
				stm_pkg::REG_STABLE_LIMIT:   stable_limit_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign adv          = v_s2_q && (!res_valid_q || !result_stall);
	assign sample_stall = v_s1_q || (v_s2_q && !adv);
	assign accept       = sample_valid && !sample_stall;

	assign first = restart || (fill_q == '0);
	assign diff  = first ? '0 : ({sample[SW-1], sample} - {sample_q[SW-1], sample_q});

	always_comb begin
		if (diff[SW] != diff[SW-1]) begin
			step_sat = diff[SW] ? stm_pkg::STEP_MIN : stm_pkg::STEP_MAX;
		end else begin
			step_sat = diff[SW-1:0];
		end
	end

	assign count_next = first ? '0 : count_q + 1'b1;

	always_comb begin
		if (first) begin
			fill_next = FILL_W'(1);
		end else if (fill_q == FILL_W'(WINDOW_DEPTH)) begin
			fill_next = fill_q;
		end else begin
			fill_next = fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			last_step_q <= '0;
			count_q     <= '0;
		end else if (accept) begin
			fill_q      <= fill_next;
			last_step_q <= step_sat;
			count_q     <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
			diff_s1  <= diff;
			step_s1  <= step_sat;
			prev_s1  <= last_step_q;
			cnt_s1   <= count_next;
			first_s1 <= first;
		end
	end

	assign accel     = {step_s1[SW-1], step_s1} - {prev_s1[SW-1], prev_s1};
	assign stable    = first_s1 || (stm_pkg::mag33(accel) < {2'b00, stable_limit_q});
	assign improving = !first_s1 && (fill_q >= FILL_W'(stm_pkg::IMPROVE_MIN_FILL))
		&& (stm_pkg::mag32(step_s1) < stm_pkg::mag32(prev_s1));

	always_ff @(posedge clk) begin
		if (v_s1_q) begin
			step_s2      <= step_s1;
			cnt_s2       <= cnt_s1;
			stable_s2    <= stable;
			improving_s2 <= improving;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1_q <= accept;
			if (v_s1_q) begin
				v_s2_q <= 1'b1;
			end else if (adv) begin
				v_s2_q <= 1'b0;
			end
			if (adv) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign feed.mag = stm_pkg::mag33(diff_s1);
	assign feed.neg = diff_s1[stm_pkg::DIFF_W-1];
	assign feed.pos = !diff_s1[stm_pkg::DIFF_W-1] && (diff_s1 != '0);

	for (genvar k = 0; k < stm_pkg::NUM_CELLS; k++) begin : g_chain
		if (k == 0) begin : g_head
			assign cell_in[k] = feed;
		end else begin : g_link
			assign cell_in[k] = cell_q[k-1].d;
		end
		stm_cell u_cell (
			.clk   (clk),
			.shift (v_s1_q),
			.din   (cell_in[k]),
			.q     (cell_q[k])
		);
	end

	stm_flags #(
		.FILL_W (FILL_W)
	) u_flags (
		.cells          (cell_q),
		.fill           (fill_q),
		.newest         (sample_q),
		.converge_limit (converge_limit_q),
		.diverge_limit  (diverge_limit_q),
		.osc_cycles     (osc_cycles_q),
		.flags          (flags)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			res_step_q      <= step_s2;
			res_count_q     <= cnt_s2;
			res_stable_q    <= stable_s2;
			res_improving_q <= improving_s2;
			res_flags_q     <= flags;
		end
	end

	assign result_valid   = res_valid_q;
	assign step           = res_step_q;
	assign update_count   = res_count_q;
	assign is_stable      = res_stable_q;
	assign is_improving   = res_improving_q;
	assign is_converged   = res_flags_q.converged;
	assign is_diverging   = res_flags_q.diverging;
	assign is_oscillating = res_flags_q.oscillating;

	`STM_ASSERT_ALWAYS(a_one_in_flight, !(v_s1_q && v_s2_q), "two words in flight")
	`STM_ASSERT_NEXT(a_s1_moves, v_s1_q, v_s2_q, "first stage word did not reach the cells")
	`STM_ASSERT_ALWAYS(a_fill_range, fill_q <= FILL_W'(WINDOW_DEPTH), "fill count past depth")
	`STM_ASSERT_NEXT(a_restart_clears, accept && restart, (fill_q == FILL_W'(1)) && (count_q == '0), "restart did not clear history")

endmodule

[dv/tb_sample_trend_monitor.sv]
module tb_sample_trend_monitor;

	import stm_pkg::*;

	localparam int DEPTH        = 16;
	localparam int PHASES       = 10;
	localparam int PER_PHASE    = 146;
	localparam int QUIET_LIMIT  = 4000;
	localparam longint STEP_HI  = 64'sd2147483647;
	localparam longint STEP_LO  = -64'sd2147483648;

	typedef struct {
		logic signed [SAMPLE_W-1:0] value;
		logic                       restart;
	} word_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] step;
		logic [SAMPLE_W-1:0]        count;
		logic                       stable;
		logic                       converged;
		logic                       diverging;
		logic                       oscillating;
		logic                       improving;
	} trend_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       sample_valid = 1'b0;
	logic                       sample_stall;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       restart = 1'b0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] step;
	logic [SAMPLE_W-1:0]        update_count;
	logic                       is_stable;
	logic                       is_converged;
	logic                       is_diverging;
	logic                       is_oscillating;
	logic                       is_improving;
	logic                       cfg_we = 1'b0;
	logic [IDX_W-1:0]           cfg_index = '0;
	logic [CFG_W-1:0]           cfg_data = '0;

	word_t  word_queue[$];
	trend_t trend_due[$];

	// Mirror of the block's settings and history.
	logic [CFG_W-1:0]           conv_lim   = CONVERGE_LIMIT_RST;
	logic [CFG_W-1:0]           div_lim    = DIVERGE_LIMIT_RST;
	logic [OSC_W-1:0]           osc_need   = OSC_CYCLES_RST;
	logic [CFG_W-1:0]           stable_lim = STABLE_LIMIT_RST;
	logic signed [SAMPLE_W-1:0] win [DEPTH];
	int                         fill = 0;
	int                         head = 0;
	logic signed [SAMPLE_W-1:0] prev_step = '0;
	logic [SAMPLE_W-1:0]        upd_cnt = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int words_taken = 0;
	int results_seen = 0;
	int quiet_cycles = 0;
	int restarts_seen = 0;
	int conv_hits = 0;
	int div_hits = 0;
	int osc_hits = 0;
	int impr_hits = 0;
	int settings_used = 1;

	sample_trend_monitor #(
		.WINDOW_DEPTH(DEPTH)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample        (sample),
		.restart       (restart),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.step          (step),
		.update_count  (update_count),
		.is_stable     (is_stable),
		.is_converged  (is_converged),
		.is_diverging  (is_diverging),
		.is_oscillating(is_oscillating),
		.is_improving  (is_improving),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint win_back(input int k);
		return longint'(win[(head + DEPTH - k) % DEPTH]);
	endfunction

	function automatic longint diff_at(input int k);
		return win_back(k) - win_back(k + 1);
	endfunction

	function automatic logic converged_now();
		if (fill < 6)
			return 1'b0;
		for (int i = 0; i < 5; i++) begin
			if (mag(diff_at(i)) >= longint'(conv_lim))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic diverging_now();
		int     n;
		int     hits = 0;
		longint g;
		longint prev = 0;
		if (fill < 3)
			return 1'b0;
		if (mag(win_back(0)) > longint'(div_lim))
			return 1'b1;
		n = (fill < 5) ? fill : 5;
		for (int i = 1; i < n; i++) begin
			g = mag(diff_at(i - 1));
			if (g * 5 > prev * 6)
				hits++;
			prev = g;
		end
		return hits >= 3;
	endfunction

	function automatic logic oscillating_now();
		int     n;
		int     changes = 0;
		longint g;
		longint prev = 0;
		if (fill < 2 * int'(osc_need))
			return 1'b0;
		n = (fill < 10) ? fill : 10;
		for (int i = 1; i < n; i++) begin
			g = diff_at(i - 1);
			if (i > 1 && ((g > 0 && prev < 0) || (g < 0 && prev > 0)))
				changes++;
			prev = g;
		end
		return changes >= int'(osc_need);
	endfunction

	task automatic predict_trend(input logic signed [SAMPLE_W-1:0] s, input logic rst,
		output trend_t r);
		longint d;
		longint accel;
		if (rst || fill == 0) begin
			head = 0;
			win[0] = s;
			fill = 1;
			prev_step = '0;
			upd_cnt = '0;
			r.step = '0;
			r.stable = 1'b1;
			r.improving = 1'b0;
		end else begin
			d = longint'(s) - win_back(0);
			if (d > STEP_HI)
				d = STEP_HI;
			if (d < STEP_LO)
				d = STEP_LO;
			r.step = d[SAMPLE_W-1:0];
			accel = longint'(r.step) - longint'(prev_step);
			r.stable = mag(accel) < longint'(stable_lim);
			head = (head + 1) % DEPTH;
			win[head] = s;
			if (fill < DEPTH)
				fill++;
			r.improving = (fill >= 3) && (mag(longint'(r.step)) < mag(longint'(prev_step)));
			prev_step = r.step;
			upd_cnt++;
		end
		r.count = upd_cnt;
		r.converged = converged_now();
		r.diverging = diverging_now();
		r.oscillating = oscillating_now();
	endtask

	task automatic check_field(input string name, input logic [SAMPLE_W-1:0] want,
		input logic [SAMPLE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : drive_blk
		trend_t r;
		word_t  w;
		if (sample_valid && !sample_stall) begin
			predict_trend(sample, restart, r);
			trend_due.push_back(r);
			words_taken++;
			if (restart)
				restarts_seen++;
		end
		if (!sample_valid || !sample_stall) begin
			if (arst_n && word_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				w = word_queue.pop_front();
				sample_valid <= 1'b1;
				sample <= w.value;
				restart <= w.restart;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin : check_blk
		trend_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (trend_due.size() == 0) begin
				$error("result word arrived with nothing expected");
				errors++;
			end else begin
				want = trend_due.pop_front();
				check_field("step", want.step, step);
				check_field("update_count", want.count, update_count);
				check_field("is_stable", SAMPLE_W'(want.stable), SAMPLE_W'(is_stable));
				check_field("is_converged", SAMPLE_W'(want.converged),
					SAMPLE_W'(is_converged));
				check_field("is_diverging", SAMPLE_W'(want.diverging),
					SAMPLE_W'(is_diverging));
				check_field("is_oscillating", SAMPLE_W'(want.oscillating),
					SAMPLE_W'(is_oscillating));
				check_field("is_improving", SAMPLE_W'(want.improving),
					SAMPLE_W'(is_improving));
				conv_hits += int'(want.converged);
				div_hits += int'(want.diverging);
				osc_hits += int'(want.oscillating);
				impr_hits += int'(want.improving);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CONVERGE_LIMIT: conv_lim = val;
			REG_DIVERGE_LIMIT:  div_lim = val;
			REG_OSC_CYCLES:     osc_need = val[OSC_W-1:0];
			REG_STABLE_LIMIT:   stable_lim = val;
			default: ;
		endcase
	endtask

	task automatic write_settings(input logic [CFG_W-1:0] conv, input logic [CFG_W-1:0] dlim,
		input logic [CFG_W-1:0] osc, input logic [CFG_W-1:0] slim);
		write_reg(REG_CONVERGE_LIMIT, conv);
		write_reg(REG_DIVERGE_LIMIT, dlim);
		write_reg(REG_OSC_CYCLES, osc);
		write_reg(REG_STABLE_LIMIT, slim);
		settings_used++;
	endtask

	task automatic push_word(input logic signed [SAMPLE_W-1:0] v, input logic rst);
		word_t w;
		w.value = v;
		w.restart = rst;
		word_queue.push_back(w);
	endtask

	// A burst is a short sequence shaped to drive one of the flags, usually opened by a restart.
	task automatic queue_burst(inout int queued);
		int     kind;
		int     len;
		int     spread;
		longint v;
		longint dv;
		longint sgn;
		logic   rst;
		kind = $urandom_range(0, 9);
		len = $urandom_range(3, 20);
		spread = $urandom_range(0, 1) ? 8 : 80;
		sgn = $urandom_range(0, 1) ? 64'sd1 : -64'sd1;
		v = longint'($signed($urandom)) >>> $urandom_range(4, 20);
		case (kind)
			4, 5:    dv = longint'($urandom_range(1, 1 << $urandom_range(0, 20)));
			6, 7:    dv = longint'($urandom_range(1, 64));
			8, 9:    dv = longint'($urandom_range(1 << 10, 1 << 18));
			default: dv = 0;
		endcase
		for (int i = 0; i < len; i++) begin
			rst = (i == 0) ? ($urandom_range(0, 4) != 0) : 1'b0;
			case (kind)
				0, 1: begin
					case ($urandom_range(0, 5))
						0:       v = STEP_HI;
						1:       v = STEP_LO;
						default: v = longint'($signed($urandom));
					endcase
					rst = ($urandom_range(0, 7) == 0);
				end
				2, 3: v += longint'($urandom_range(0, 2 * spread)) - spread;
				4, 5: begin
					if ($urandom_range(0, 7) != 0)
						v += (i % 2) ? dv : -dv;
				end
				6, 7: begin
					v += sgn * dv;
					dv = dv * longint'($urandom_range(11, 20)) / 10 + 1;
				end
				default: begin
					v += sgn * dv;
					dv = dv * longint'($urandom_range(5, 9)) / 10;
				end
			endcase
			push_word(v[SAMPLE_W-1:0], rst);
			queued++;
		end
	endtask

	task automatic drain();
		while (word_queue.size() != 0 || sample_valid || trend_due.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin : stim_blk
		int queued;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first word is taken as a restart even with restart low; then both saturations.
		push_word(32'sh7FFF_FFFF, 1'b0);
		push_word(32'sh8000_0000, 1'b0);
		push_word(32'sh7FFF_FFFF, 1'b0);
		push_word(32'sh8000_0000, 1'b1);
		push_word(32'sd0, 1'b1);
		for (int i = 1; i <= 6; i++)
			push_word(10 * i, 1'b0);
		for (int i = 0; i < 6; i++)
			push_word((i % 2) ? -1000 : 1000, 1'b0);
		push_word(0, 1'b1);
		push_word(1, 1'b0);
		push_word(3, 1'b0);
		push_word(8, 1'b0);
		push_word(20, 1'b0);
		push_word(50, 1'b0);
		push_word(100, 1'b0);
		push_word(150, 1'b0);
		push_word(170, 1'b0);
		push_word(-1, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: ;
				1: write_settings(31'h7FFF_FFFF, 31'd0, 31'd1, 31'd0);
				2: write_settings(31'd0, 31'h7FFF_FFFF, 31'd8, 31'h7FFF_FFFF);
				3: write_settings(31'd4000, 31'd1 << 22, 31'd0, 31'd65536);
				4: write_settings(31'd200, 31'd1 << 26, 31'd15, 31'd5000);
				default: write_settings(CFG_W'($urandom_range(0, 1 << $urandom_range(0, 16))),
					CFG_W'($urandom >> $urandom_range(1, 12)), CFG_W'($urandom_range(1, 8)),
					CFG_W'($urandom_range(0, 1 << 17)));
			endcase
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			queued = 0;
			while (queued < PER_PHASE)
				queue_burst(queued);
			drain();
		end

		$display("Run covered %0d words (%0d restarts) under %0d register settings.",
			words_taken, restarts_seen, settings_used);
		$display("Results checked: %0d; converged %0d, diverging %0d, oscillating %0d, improving %0d.",
			results_seen, conv_hits, div_hits, osc_hits, impr_hits);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/stm_pkg.sv
src/stm_cell.sv
src/stm_flags.sv
src/sample_trend_monitor.sv
dv/tb_sample_trend_monitor.sv
